FILE: hw/rtl/hcc_pkg.sv
// Shared types, curve tables and per-level step functions for the Hilbert curve converter.
package hcc_pkg;

    // Fixed field widths.
    localparam int COORD_W = 32;
    localparam int INDEX_W = 64;
    localparam int ORDER_W = 6;
    localparam int BIT_W   = 5;

    // Curve levels evaluated between two pipeline registers.
    localparam int LEVELS_PER_STAGE = 4;

    // Function selector codes.
    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    // Packed state tables, indexed by row = {state, two input bits}.
    localparam logic [31:0] ENC_DIGIT = 32'h361E9CB4;
    localparam logic [31:0] ENC_NEXT  = 32'h8FE65831;
    localparam logic [15:0] DEC_XBIT  = 16'h936C;
    localparam logic [15:0] DEC_YBIT  = 16'h39C6;
    localparam logic [31:0] DEC_NEXT  = 32'h3E6B94C1;

    // Work word that travels down the pipeline.
    typedef struct packed {
        logic               func;
        logic [1:0]         st;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [INDEX_W-1:0] d;
    } t_stage;

    // Two-bit entry of a packed 16-row table.
    function automatic logic [1:0] tbl2(logic [31:0] tbl, logic [3:0] row);
        logic [31:0] tmp;
        tmp = tbl >> {row, 1'b0};
        return tmp[1:0];
    endfunction

    // One curve level at bit position b; an inactive level passes the word unchanged.
    function automatic t_stage hcc_level(t_stage s_in, logic [BIT_W-1:0] b, logic act);
        t_stage     s_out;
        logic [3:0] row;
        s_out = s_in;
        if (s_in.func == FUNC_ENC) begin
            row = {s_in.st, s_in.x[b], s_in.y[b]};
        end else begin
            row = {s_in.st, s_in.d[{b, 1'b0} +: 2]};
        end
        if (act) begin
            if (s_in.func == FUNC_ENC) begin
                s_out.d[{b, 1'b0} +: 2] = tbl2(ENC_DIGIT, row);
                s_out.st                = tbl2(ENC_NEXT, row);
            end else begin
                s_out.x[b] = DEC_XBIT[row];
                s_out.y[b] = DEC_YBIT[row];
                s_out.st   = tbl2(DEC_NEXT, row);
            end
        end
        return s_out;
    endfunction

endpackage

FILE: hw/rtl/hilbert_curve_converter.sv
// Top level of the Hilbert curve converter, a pipeline of curve-table steps.
// Throughput is one item per cycle while the output is not stalled;
// each stage evaluates four table levels of the curve walk.
// A stalled output holds its item while empty stages upstream keep accepting.
// Synchronous active-low reset clears all valid bits and sets the curve order to 32.
module hilbert_curve_converter
    import hcc_pkg::*;
#(
    parameter int MAX_ORDER = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: curve order.
    input  logic                 i_cfg_we,
    input  logic [ORDER_W-1:0]   i_cfg_wdata,
    // Input items.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata, lowest bit up: x_coord[31:0], y_coord[63:32], curve_index_in[127:64].
    input  logic [127:0]         s_axis_tdata,
    // tuser: func.
    input  logic                 s_axis_tuser,
    // Result items.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata, lowest bit up: curve_index_out[63:0], x_out[95:64], y_out[127:96].
    output logic [127:0]         m_axis_tdata
);

    localparam int NUM_STAGES = (MAX_ORDER + LEVELS_PER_STAGE - 1) / LEVELS_PER_STAGE;

    logic [ORDER_W-1:0] r_order;
    logic [ORDER_W-1:0] w_eff;
    t_stage             r_stg [NUM_STAGES+1];
    t_stage             n_stg [NUM_STAGES+1];
    logic [NUM_STAGES:0] r_vld;
    logic [NUM_STAGES:0] w_rdy;

    // Curve order register, saturated to the levels that are built.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_W'(32);
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    assign w_eff = (r_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : r_order;

    // Input stage: the field that becomes the result starts cleared.
    always_comb begin
        n_stg[0].func = s_axis_tuser;
        n_stg[0].st   = 2'b00;
        n_stg[0].x    = s_axis_tdata[31:0];
        n_stg[0].y    = s_axis_tdata[63:32];
        n_stg[0].d    = s_axis_tdata[127:64];
        if (s_axis_tuser == FUNC_ENC) begin
            n_stg[0].d = '0;
        end else begin
            n_stg[0].x = '0;
            n_stg[0].y = '0;
        end
    end

    // Table stages, four curve levels each, from the top bit down.
    for (genvar s = 1; s <= NUM_STAGES; s++) begin : g_stage
        t_stage w_chain [LEVELS_PER_STAGE+1];
        assign w_chain[0] = r_stg[s-1];
        for (genvar k = 0; k < LEVELS_PER_STAGE; k++) begin : g_level
            localparam int B = MAX_ORDER - 1 - LEVELS_PER_STAGE * (s - 1) - k;
            if (B >= 0) begin : g_act
                assign w_chain[k+1] = hcc_level(w_chain[k], BIT_W'(B),
                                                ORDER_W'(B) < w_eff);
            end else begin : g_pass
                assign w_chain[k+1] = w_chain[k];
            end
        end
        assign n_stg[s] = w_chain[LEVELS_PER_STAGE];
    end

    // Per-stage ready: a stage takes a new item when empty or when it drains.
    assign w_rdy[NUM_STAGES] = !r_vld[NUM_STAGES] || m_axis_tready;
    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_rdy
        assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];
    end

    // Valid bits and payload registers.
    for (genvar s = 0; s <= NUM_STAGES; s++) begin : g_reg
        logic w_in_vld;
        if (s == 0) begin : g_first
            assign w_in_vld = s_axis_tvalid;
        end else begin : g_next
            assign w_in_vld = r_vld[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_vld[s] <= w_in_vld;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_rdy[s] && w_in_vld) begin
                r_stg[s] <= n_stg[s];
            end
        end
    end

    // Result: the unused side of each function reads as zero.
    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[NUM_STAGES];
    always_comb begin
        if (r_stg[NUM_STAGES].func == FUNC_ENC) begin
            m_axis_tdata = {64'd0, r_stg[NUM_STAGES].d};
        end else begin
            m_axis_tdata = {r_stg[NUM_STAGES].y, r_stg[NUM_STAGES].x, 64'd0};
        end
    end

endmodule

FILE: hw/rtl/hcc_checker.sv
// Port-level checker for the Hilbert curve converter and its bind to the top level.
module hcc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    // A stalled result keeps its data.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // Every result is either an index or a coordinate pair, never both.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:0] == 64'd0) || (m_axis_tdata[127:64] == 64'd0))
        else $error("result carries both an index and coordinates");

    // With the output stage empty the whole pipeline can take an item.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output stage");

    // No result is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid directly after reset");

endmodule

bind hilbert_curve_converter hcc_checker u_hcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
